// ----- hw/rtl/egcd_pkg.sv -----
// Shared types and constants for the extended GCD block.
// No dependencies; imported by egcd_ctrl, egcd_dp and extended_gcd_bezout.
package egcd_pkg;

    localparam int A_W      = 32;
    localparam int GCD_W    = 32;
    localparam int COEF_W   = 33;
    localparam int IN_TW    = 64;
    localparam int OUT_TW   = 104;
    localparam int OUT_USED = GCD_W + 2 * COEF_W;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic out_load;
    } egcd_cmd_t;

    typedef struct packed {
        logic r1_zero;
    } egcd_stat_t;

endpackage

// ----- hw/rtl/egcd_dp.sv -----
// Datapath: remainder and coefficient rows, restoring divider, output register.
// Depends on egcd_pkg; driven by egcd_ctrl commands.
module egcd_dp
    import egcd_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  egcd_cmd_t         cmd,
    output egcd_stat_t        stat,
    input  logic [A_W-1:0]    a_value,
    input  logic [A_W-1:0]    b_value,
    output logic [GCD_W-1:0]  gcd_value,
    output logic [COEF_W-1:0] coef_x,
    output logic [COEF_W-1:0] coef_y
);

    logic [DATA_W-1:0] r0_reg, r1_reg, rem_reg, dvd_reg;
    logic [COEF_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg, accx_reg, accy_reg;
    logic [GCD_W-1:0]  gcd_reg;
    logic [COEF_W-1:0] ox_reg, oy_reg;

    logic [DATA_W:0]   trial;
    logic              ge;
    logic [DATA_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, r1_reg};
    assign ge    = (trial >= {1'b0, r1_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r0_reg <= a_value[DATA_W-1:0];
            r1_reg <= b_value[DATA_W-1:0];
            x0_reg <= COEF_W'(1);
            x1_reg <= '0;
            y0_reg <= '0;
            y1_reg <= COEF_W'(1);
        end
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            dvd_reg  <= r0_reg;
            accx_reg <= '0;
            accy_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            dvd_reg  <= {dvd_reg[DATA_W-2:0], ge};
            accx_reg <= {accx_reg[COEF_W-2:0], 1'b0} + (ge ? x1_reg : '0);
            accy_reg <= {accy_reg[COEF_W-2:0], 1'b0} + (ge ? y1_reg : '0);
        end
        if (cmd.update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            x0_reg <= x1_reg;
            x1_reg <= x0_reg - accx_reg;
            y0_reg <= y1_reg;
            y1_reg <= y0_reg - accy_reg;
        end
        if (cmd.out_load)
        begin
            gcd_reg <= GCD_W'(r0_reg);
            ox_reg  <= x0_reg;
            oy_reg  <= y0_reg;
        end
    end

    assign stat.r1_zero = (r1_reg == '0);
    assign gcd_value    = gcd_reg;
    assign coef_x       = ox_reg;
    assign coef_y       = oy_reg;

endmodule

// ----- hw/rtl/egcd_ctrl.sv -----
// Controller: sequences Euclid steps, divider bit count and output handshake.
// Depends on egcd_pkg; commands egcd_dp.
module egcd_ctrl
    import egcd_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  egcd_stat_t stat,
    output egcd_cmd_t  cmd
);

    localparam int CW = $clog2(DATA_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.r1_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = CW'(DATA_W - 1);
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/extended_gcd_bezout.sv -----
// Top level: extended Euclidean GCD with Bezout coefficients.
// Depends on egcd_pkg, egcd_ctrl and egcd_dp.
//
// Channel  Direction  Width  Contents (low bit up)
// s_axis   in         64     a_value[31:0], b_value[31:0]
// m_axis   out        104    gcd_value[31:0], coef_x[32:0], coef_y[32:0], zero pad
//
// Each Euclid step is one check, the bit-serial restoring divider with shift-add
// coefficient products over W quotient bits (W = min(OPERAND_WIDTH, 32)), and
// one row update. One item is in flight; a finished result waits in the output
// register while the next item is taken. Reset clears control only.
module extended_gcd_bezout
    import egcd_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // a_value, b_value
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_TW-1:0] m_axis_tdata    // gcd_value, coef_x, coef_y, pad
);

    localparam int DATA_W = (OPERAND_WIDTH < A_W) ? OPERAND_WIDTH : A_W;

    egcd_cmd_t         cmd;
    egcd_stat_t        stat;
    logic [GCD_W-1:0]  gcd_value;
    logic [COEF_W-1:0] coef_x, coef_y;

    egcd_ctrl #(.DATA_W(DATA_W)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    egcd_dp #(.DATA_W(DATA_W)) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .stat      (stat),
        .a_value   (s_axis_tdata[A_W-1:0]),
        .b_value   (s_axis_tdata[2*A_W-1:A_W]),
        .gcd_value (gcd_value),
        .coef_x    (coef_x),
        .coef_y    (coef_y)
    );

    assign m_axis_tdata = {{(OUT_TW - OUT_USED){1'b0}}, coef_y, coef_x, gcd_value};

endmodule

// ----- hw/rtl/egcd_checker.sv -----
// Port-level checks for extended_gcd_bezout, attached by bind.
// Depends on egcd_pkg.
module egcd_checker
    import egcd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_TW-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_new_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a finished item");

    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[GCD_W-1:0] == '0) |->
            (m_axis_tdata[GCD_W+COEF_W-1:GCD_W] == COEF_W'(1)) &&
            (m_axis_tdata[GCD_W+2*COEF_W-1:GCD_W+COEF_W] == '0))
        else $error("zero gcd with wrong coefficients");

endmodule

bind extended_gcd_bezout egcd_checker u_egcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/extended_gcd_bezout_checker.sv -----
// Checker for extended_gcd_bezout: watches both stream channels, predicts gcd and
// Bezout coefficients for every accepted operand pair, and compares the results in order.
// Depends on egcd_pkg.
module extended_gcd_bezout_checker
    import egcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [IN_TW-1:0]  s_axis_tdata,   // a_value, b_value
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [OUT_TW-1:0] m_axis_tdata,   // gcd_value, coef_x, coef_y, pad
    output int                fail_count,
    output int                pending,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [A_W-1:0]           a;
        logic [A_W-1:0]           b;
        logic [GCD_W-1:0]         gcd;
        logic signed [COEF_W-1:0] x;
        logic signed [COEF_W-1:0] y;
    } bezout_t;

    bezout_t bezout_q[$];
    int      errs;
    int      results;

    // Row reduction on 64-bit words; coefficients wrap the same way the hardware does.
    function automatic bezout_t solve_bezout(logic [A_W-1:0] a, logic [A_W-1:0] b);
        logic [63:0] r0, r1, x0, x1, y0, y1, q, nx, ny, nr;
        bezout_t     res;
        r0 = 64'(a);
        r1 = 64'(b);
        x0 = 64'd1;
        x1 = 64'd0;
        y0 = 64'd0;
        y1 = 64'd1;
        while (r1 != 64'd0)
        begin
            q  = r0 / r1;
            nx = x0 - q * x1;
            ny = y0 - q * y1;
            nr = r0 - q * r1;
            x0 = x1;
            y0 = y1;
            r0 = r1;
            x1 = nx;
            y1 = ny;
            r1 = nr;
        end
        res.a   = a;
        res.b   = b;
        res.gcd = r0[GCD_W-1:0];
        res.x   = x0[COEF_W-1:0];
        res.y   = y0[COEF_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        bezout_t                  want;
        logic [GCD_W-1:0]         got_gcd;
        logic signed [COEF_W-1:0] got_x;
        logic signed [COEF_W-1:0] got_y;
        logic                     bad;
        if (!rst_n)
        begin
            bezout_q.delete();
            errs         = 0;
            results      = 0;
            fail_count   <= 0;
            pending      <= 0;
            result_count <= 0;
        end
        else
        begin
            // results first: a transfer in on the same edge cannot be the one coming out
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_gcd = m_axis_tdata[GCD_W-1:0];
                got_x   = m_axis_tdata[GCD_W +: COEF_W];
                got_y   = m_axis_tdata[GCD_W+COEF_W +: COEF_W];
                results++;
                if (bezout_q.size() == 0)
                begin
                    $display("%0t: unexpected result gcd %0d x %0d y %0d", $time,
                             got_gcd, got_x, got_y);
                    errs++;
                end
                else
                begin
                    want = bezout_q.pop_front();
                    bad  = 1'b0;
                    if (got_gcd !== want.gcd)
                    begin
                        $display("%0t: a=%0d b=%0d gcd expected %0d, actual %0d", $time,
                                 want.a, want.b, want.gcd, got_gcd);
                        bad = 1'b1;
                    end
                    if (got_x !== want.x)
                    begin
                        $display("%0t: a=%0d b=%0d coef_x expected %0d, actual %0d", $time,
                                 want.a, want.b, want.x, got_x);
                        bad = 1'b1;
                    end
                    if (got_y !== want.y)
                    begin
                        $display("%0t: a=%0d b=%0d coef_y expected %0d, actual %0d", $time,
                                 want.a, want.b, want.y, got_y);
                        bad = 1'b1;
                    end
                    if (m_axis_tdata[OUT_TW-1:OUT_USED] !== '0)
                    begin
                        $display("%0t: a=%0d b=%0d pad expected 0, actual %h", $time,
                                 want.a, want.b, m_axis_tdata[OUT_TW-1:OUT_USED]);
                        bad = 1'b1;
                    end
                    if (bad)
                        errs++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                bezout_q.push_back(solve_bezout(s_axis_tdata[A_W-1:0],
                                                s_axis_tdata[2*A_W-1:A_W]));
            fail_count   <= errs;
            pending      <= bezout_q.size();
            result_count <= results;
        end
    end

endmodule

// ----- tb/tb_extended_gcd_bezout.sv -----
// Testbench top for extended_gcd_bezout: clock, reset, operand stimulus, result-side
// back-pressure and the verdict. Depends on egcd_pkg, the block and extended_gcd_bezout_checker.
module tb_extended_gcd_bezout;
    timeunit 1ns;
    timeprecision 1ps;

    import egcd_pkg::*;

    localparam int RAND_ITEMS   = 400;
    localparam int QUIET_TAIL   = 60;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_CYCLES  = 4000;
    localparam int DRAIN_CYCLES = 2000;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_TW-1:0]  s_axis_tdata  = '0;   // a_value, b_value
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_TW-1:0] m_axis_tdata;         // gcd_value, coef_x, coef_y, pad

    int   fail_count;
    int   pending;
    int   result_count;
    int   sent_count     = 0;
    int   directed_count = 0;
    bit   quiet          = 1'b0;
    bit   held           = 1'b0;

    always #2 clk = ~clk;

    extended_gcd_bezout u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    extended_gcd_bezout_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic push_operands(input logic [A_W-1:0] a, input logic [A_W-1:0] b);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic pick_operands(output logic [A_W-1:0] a, output logic [A_W-1:0] b);
        logic [A_W-1:0] g, f0, f1, t;
        int             k;
        case ($urandom_range(0, 9))
            1:
            begin
                g = $urandom_range(1, 65535);
                a = g * $urandom_range(0, 65535);
                b = g * $urandom_range(0, 65535);
            end
            2:
            begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            3:
            begin
                a = $urandom_range(0, 3) == 0 ? A_W'(1) : $urandom();
                b = $urandom_range(0, 1) == 0 ? '0 : A_W'(1);
                if ($urandom_range(0, 1) == 1)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            4:
            begin
                a = $urandom();
                b = $urandom();
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            5:
            begin
                // consecutive Fibonacci numbers: longest chain of quotient-one steps
                f0 = '0;
                f1 = A_W'(1);
                k  = $urandom_range(2, 46);
                repeat (k)
                begin
                    t  = f0 + f1;
                    f0 = f1;
                    f1 = t;
                end
                a = $urandom_range(0, 1) == 0 ? f1 : f0;
                b = (a == f1) ? f0 : f1;
            end
            6:
            begin
                a = $urandom();
                b = a - $urandom_range(0, 16);
            end
            7:
            begin
                a = A_W'(1) << $urandom_range(0, A_W - 1);
                b = {A_W{1'b1}} >> $urandom_range(0, A_W - 1);
            end
            default:
            begin
                a = $urandom();
                b = $urandom();
            end
        endcase
    endtask

    initial
    begin : operand_source
        logic [A_W-1:0] a, b;
        int             i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_operands(32'd0, 32'd0);
        push_operands(32'hFFFF_FFFF, 32'd0);
        push_operands(32'd0, 32'hFFFF_FFFF);
        push_operands(32'd0, 32'd1);
        push_operands(32'd1, 32'd1);
        push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_operands(32'hFFFF_FFFF, 32'd1);
        push_operands(32'd1, 32'hFFFF_FFFF);
        push_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        push_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        push_operands(32'd2971215073, 32'd1836311903);
        push_operands(32'd1836311903, 32'd2971215073);
        push_operands(32'd240, 32'd46);
        push_operands(32'd12, 32'd18);
        push_operands(32'h8000_0000, 32'h8000_0000);
        push_operands(32'h8000_0000, 32'd1);
        push_operands(32'h8000_0000, 32'h4000_0000);
        push_operands(32'd4294967291, 32'd4294967279);
        push_operands(32'hAAAA_AAAA, 32'h5555_5555);
        push_operands(32'h5555_5555, 32'hAAAA_AAAA);
        push_operands(32'd3, 32'h8000_0001);
        directed_count = sent_count;

        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i >= RAND_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            pick_operands(a, b);
            push_operands(a, b);
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operand pairs (%0d directed, %0d random) with bursty idle on both",
                 sent_count, directed_count, sent_count - directed_count);
        $display("sides and a %0d-cycle output hold; %0d results compared.",
                 HOLD_CYCLES, result_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : result_sink
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent_count >= HOLD_AFTER)
            begin
                // long hold so the result register and the input side both back up
                held = 1'b1;
                m_axis_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        #15_000_000;
        $display("Timeout with %0d transfers still outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
